// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/kroot_pkg.sv =====
package kroot_pkg;

   localparam int BASE_BITS = 32;
   localparam int BIT_IDX_BITS = 5;
   localparam int DEG_BITS = 8;
   localparam int PROD_BITS = 2 * BASE_BITS;

   typedef logic [BASE_BITS-1:0] base_type;
   typedef logic [PROD_BITS-1:0] prod_type;
   typedef logic [DEG_BITS-1:0] deg_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_MLO   = 6'b000100,
      ST_MHI   = 6'b001000,
      ST_ACC   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

// ===== rtl/kroot_mul.sv =====
module kroot_mul (
   input  logic               clock,
   input  kroot_pkg::base_type op_a,
   input  kroot_pkg::base_type op_b,
   output kroot_pkg::prod_type prod_ff
);
   import kroot_pkg::*;

   prod_type prod_in;

   assign prod_in = PROD_BITS'(op_a) * PROD_BITS'(op_b);

   // register every product; the sequencer picks the cycle it needs
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/integer_kth_root_remainder.sv =====
// Integer k-th root with remainder, one item at a time.
// Zero value, zero degree and degree one are answered straight from idle; otherwise
// each of the 32 candidate bits takes at most one multiplication per power step,
// all on the single shared 32x32 multiplier.
// Throughput: the next item is taken in the cycle its predecessor's result shows.
// Reset (synchronous, active high) returns the sequencer to idle, drops the strobe.
module integer_kth_root_remainder #(
   parameter int VALUE_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [63:0]                req_value,
   input  kroot_pkg::deg_type         req_degree,
   output logic                       rsp_valid,
   output kroot_pkg::base_type        rsp_root_base,
   output logic [63:0]                rsp_root_remainder,
   output logic                       rsp_valid_res
);
   import kroot_pkg::*;

   localparam int SUM_BITS = PROD_BITS + BASE_BITS;

   // sequencer state
   state_type state_ff, state_in;
   logic [BIT_IDX_BITS-1:0] bit_ff, bit_in;
   deg_type cnt_ff, cnt_in;

   // working data
   logic [VALUE_BITS-1:0] val_ff, val_in;
   deg_type deg_ff, deg_in;
   base_type base_ff, base_in;
   logic [VALUE_BITS-1:0] pow_ff, pow_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   prod_type plo_ff, plo_in;

   // result registers
   logic rsp_valid_ff, rsp_valid_in;
   base_type rsp_base_ff, rsp_base_in;
   logic [63:0] rsp_rem_ff, rsp_rem_in;
   logic rsp_res_ff, rsp_res_in;

   // datapath
   logic [VALUE_BITS-1:0] req_val_m;
   logic [63:0] req_val64;
   base_type req_sat;
   base_type bit_mask, cand;
   logic [63:0] acc64;
   base_type mul_a;
   prod_type mul_prod;
   logic [SUM_BITS-1:0] sum;
   logic sum_fits;
   logic [12:0] bit_weight;
   logic too_big;
   deg_type cnt_nx;

   assign req_val_m = req_value[VALUE_BITS-1:0];
   assign req_val64 = 64'(req_val_m);
   assign req_sat = (req_val64 > 64'(base_type'('1))) ? '1 : req_val64[BASE_BITS-1:0];

   assign bit_mask = base_type'(1) << bit_ff;
   assign cand = base_ff | bit_mask;
   assign acc64 = 64'(acc_ff);

   // low half of the running power first, high half next
   assign mul_a = (state_ff == ST_MLO) ? acc64[BASE_BITS-1:0] : acc64[63:BASE_BITS];

   kroot_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (cand),
      .prod_ff (mul_prod)
   );

   // in ST_ACC the multiplier holds the high partial product
   assign sum = {mul_prod, {BASE_BITS{1'b0}}} + SUM_BITS'(plo_ff);
   assign sum_fits = (sum <= SUM_BITS'(val_ff));

   // cand >= 2^bit, so its power is at least 2^(bit*degree): no need to multiply
   assign bit_weight = 13'(bit_ff) * 13'(deg_ff);
   assign too_big = (bit_weight >= 13'(VALUE_BITS));

   assign cnt_nx = cnt_ff + deg_type'(1);

   always_comb begin
      state_in = state_ff;
      bit_in = bit_ff;
      cnt_in = cnt_ff;
      val_in = val_ff;
      deg_in = deg_ff;
      base_in = base_ff;
      pow_in = pow_ff;
      acc_in = acc_ff;
      plo_in = plo_ff;
      rsp_valid_in = 1'b0;
      rsp_base_in = rsp_base_ff;
      rsp_rem_in = rsp_rem_ff;
      rsp_res_in = rsp_res_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in = req_val_m;
               deg_in = req_degree;
               base_in = '0;
               pow_in = '0;
               bit_in = '1;
               if (req_val_m == '0 || req_degree == '0) begin
                  // invalid item: answer at once with zeros
                  rsp_valid_in = 1'b1;
                  rsp_base_in = '0;
                  rsp_rem_in = '0;
                  rsp_res_in = 1'b0;
               end else if (req_degree == deg_type'(1)) begin
                  // first root: the value itself, saturated to the base width
                  rsp_valid_in = 1'b1;
                  rsp_base_in = req_sat;
                  rsp_rem_in = req_val64 - 64'(req_sat);
                  rsp_res_in = 1'b1;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            if (too_big) begin
               // drop this bit without multiplying
               if (bit_ff == '0) state_in = ST_DONE;
               else bit_in = bit_ff - BIT_IDX_BITS'(1);
            end else if (cand == base_type'(1)) begin
               // one to any power is one, and the value is at least one
               base_in = cand;
               pow_in = VALUE_BITS'(1);
               state_in = ST_DONE;
            end else begin
               acc_in = VALUE_BITS'(cand);
               cnt_in = deg_type'(1);
               state_in = ST_MLO;
            end
         end

         ST_MLO: begin
            state_in = ST_MHI;
         end

         ST_MHI: begin
            plo_in = mul_prod;
            state_in = ST_ACC;
         end

         ST_ACC: begin
            if (!sum_fits) begin
               if (bit_ff == '0) state_in = ST_DONE;
               else begin
                  bit_in = bit_ff - BIT_IDX_BITS'(1);
                  state_in = ST_CHECK;
               end
            end else begin
               acc_in = sum[VALUE_BITS-1:0];
               cnt_in = cnt_nx;
               if (cnt_nx == deg_ff) begin
                  // candidate power fits: keep the bit and its power
                  base_in = cand;
                  pow_in = sum[VALUE_BITS-1:0];
                  if (bit_ff == '0) state_in = ST_DONE;
                  else begin
                     bit_in = bit_ff - BIT_IDX_BITS'(1);
                     state_in = ST_CHECK;
                  end
               end else begin
                  state_in = ST_MLO;
               end
            end
         end

         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_base_in = base_ff;
            rsp_rem_in = 64'(val_ff - pow_ff);
            rsp_res_in = 1'b1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      deg_ff <= deg_in;
      base_ff <= base_in;
      pow_ff <= pow_in;
      acc_ff <= acc_in;
      plo_ff <= plo_in;
      rsp_base_ff <= rsp_base_in;
      rsp_rem_ff <= rsp_rem_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_root_base = rsp_base_ff;
   assign rsp_root_remainder = rsp_rem_ff;
   assign rsp_valid_res = rsp_res_ff;

endmodule

// ===== rtl/kroot_check.sv =====
`include "assert_macros.svh"

module kroot_check (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [63:0]         req_value,
   input kroot_pkg::deg_type  req_degree,
   input logic                rsp_valid,
   input kroot_pkg::base_type rsp_root_base,
   input logic [63:0]         rsp_root_remainder,
   input logic                rsp_valid_res
);
   import kroot_pkg::*;

   logic take_invalid;
   logic rsp_zero;

   assign take_invalid = start && !busy && (req_degree == '0 || req_value == '0);
   assign rsp_zero = (rsp_root_base == '0) && (rsp_root_remainder == '0);

   `ASSERT_SAME(a_strobe_idle, rsp_valid, !busy, "result shown while still busy")
   `ASSERT_SAME(a_invalid_zero, rsp_valid && !rsp_valid_res, rsp_zero, "invalid result not zero")
   `ASSERT_SAME(a_valid_base, rsp_valid && rsp_valid_res, rsp_root_base != '0, "zero base")
   `ASSERT_NEXT(a_invalid_next, take_invalid, rsp_valid && !rsp_valid_res, "invalid not flagged")

endmodule

bind integer_kth_root_remainder kroot_check u_kroot_check (.*);
